[rtl/core/setup_tardiness_cost_evaluator_assert.svh]
// Assertion macros for the setup tardiness cost evaluator checker.
// Expects signals named clk and arst_n in the scope of use.
`ifndef SETUP_TARDINESS_COST_EVALUATOR_ASSERT_SVH
`define SETUP_TARDINESS_COST_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/stc_pkg.sv]
// Shared widths, codes and pipeline payload types of the tardiness cost evaluator.
// No dependencies.
package stc_pkg;

	localparam int MAX_JOBS_DEFAULT = 64;

	localparam int JOB_W   = 6;
	localparam int SETUP_W = 16;
	localparam int PROD_W  = 16;
	localparam int TIME_W  = 24;
	localparam int RATE_W  = 10;
	localparam int PEN_W   = 34;
	localparam int COST_W  = 40;
	localparam int LIM_W   = 9;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_JOB  = 1'b1;

	// job waiting for its setup time from the table
	typedef struct packed {
		logic              valid;
		logic              oob;
		logic [PROD_W-1:0] prod;
		logic [TIME_W-1:0] due;
		logic [RATE_W-1:0] rate;
		logic              last;
	} s1_job_t;

	// job with its completion time known
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] done;
		logic [TIME_W-1:0] due;
		logic [RATE_W-1:0] rate;
		logic              last;
	} s2_job_t;

endpackage

[rtl/core/stc_in_if.sv]
// Input channel of the tardiness cost evaluator: setup loads and jobs.
// Depends on stc_pkg.
interface stc_in_if;
	import stc_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [JOB_W-1:0]  setup_row;
	logic [JOB_W-1:0]  setup_col;
	logic [SETUP_W-1:0] setup_time;
	logic [JOB_W-1:0]  job_index;
	logic [PROD_W-1:0] production_time;
	logic [TIME_W-1:0] due_time;
	logic [RATE_W-1:0] penalty_rate;
	logic              last_job;

	modport source (
		output valid, kind, setup_row, setup_col, setup_time, job_index,
		       production_time, due_time, penalty_rate, last_job,
		input  ready
	);

	modport sink (
		input  valid, kind, setup_row, setup_col, setup_time, job_index,
		       production_time, due_time, penalty_rate, last_job,
		output ready
	);

endinterface

[rtl/core/stc_out_if.sv]
// Result channel of the tardiness cost evaluator: one result per job.
// Depends on stc_pkg.
interface stc_out_if;
	import stc_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] completion_time;
	logic [PEN_W-1:0]  job_penalty;
	logic [COST_W-1:0] running_cost;
	logic              schedule_end;

	modport source (
		output valid, completion_time, job_penalty, running_cost, schedule_end,
		input  ready
	);

	modport sink (
		input  valid, completion_time, job_penalty, running_cost, schedule_end,
		output ready
	);

endinterface

[rtl/core/stc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/stc_clock.sv]
// Running schedule clock: adds setup and production time, saturating.
// Depends on stc_pkg.
module stc_clock (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stc_pkg::s1_job_t              job_s1,
	input  logic [stc_pkg::SETUP_W-1:0]   setup_rd,
	output logic                          s1_take,
	output stc_pkg::s2_job_t              job_s2,
	input  logic                          s2_take
);
	import stc_pkg::*;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
	                                              input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	logic [TIME_W-1:0] elapsed_q;
	logic [TIME_W-1:0] setup_ext;
	logic [TIME_W-1:0] start_t;
	logic [TIME_W-1:0] done_t;
	logic              adv;

	logic              valid_s2;
	logic [TIME_W-1:0] done_s2;
	logic [TIME_W-1:0] due_s2;
	logic [RATE_W-1:0] rate_s2;
	logic              last_s2;

	// out-of-range table index reads as zero setup
	assign setup_ext = job_s1.oob ? '0 : TIME_W'(setup_rd);
	assign start_t   = sat_add(elapsed_q, setup_ext);
	assign done_t    = sat_add(start_t, TIME_W'(job_s1.prod));

	assign s1_take = !valid_s2 || s2_take;
	assign adv     = job_s1.valid && s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			valid_s2  <= 1'b0;
		end else begin
			if (s1_take) begin
				valid_s2 <= job_s1.valid;
			end
			if (adv) begin
				elapsed_q <= job_s1.last ? '0 : done_t;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_s2 <= done_t;
			due_s2  <= job_s1.due;
			rate_s2 <= job_s1.rate;
			last_s2 <= job_s1.last;
		end
	end

	assign job_s2 = '{valid: valid_s2, done: done_s2, due: due_s2,
	                  rate: rate_s2, last: last_s2};

endmodule

[rtl/core/stc_cost.sv]
// Lateness, penalty product and saturating running cost, with the result register.
// Depends on stc_pkg and stc_out_if.
module stc_cost (
	input  logic             clk,
	input  logic             arst_n,
	input  stc_pkg::s2_job_t job_s2,
	output logic             s2_take,
	stc_out_if.source        results
);
	import stc_pkg::*;

	logic              en_out, en_s4, en_s3;

	logic              valid_s3;
	logic [TIME_W-1:0] late_s3;
	logic [RATE_W-1:0] rate_s3;
	logic [TIME_W-1:0] done_s3;
	logic              last_s3;

	logic              valid_s4;
	logic [PEN_W-1:0]  pen_s4;
	logic [TIME_W-1:0] done_s4;
	logic              last_s4;

	logic              out_valid_q;
	logic [TIME_W-1:0] completion_q;
	logic [PEN_W-1:0]  penalty_q;
	logic [COST_W-1:0] cost_q;
	logic              end_q;
	logic [COST_W-1:0] total_q;

	logic [TIME_W-1:0] late_t;
	logic [COST_W:0]   sum_t;
	logic [COST_W-1:0] total_next;

	assign en_out  = !out_valid_q || results.ready;
	assign en_s4   = !valid_s4 || en_out;
	assign en_s3   = !valid_s3 || en_s4;
	assign s2_take = en_s3;

	assign late_t     = (job_s2.done > job_s2.due) ? job_s2.done - job_s2.due : '0;
	assign sum_t      = {1'b0, total_q} + (COST_W+1)'(pen_s4);
	assign total_next = sum_t[COST_W] ? {COST_W{1'b1}} : sum_t[COST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (en_s3) begin
				valid_s3 <= job_s2.valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
			if (en_out) begin
				out_valid_q <= valid_s4;
			end
			if (en_out && valid_s4) begin
				total_q <= last_s4 ? '0 : total_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && job_s2.valid) begin
			late_s3 <= late_t;
			rate_s3 <= job_s2.rate;
			done_s3 <= job_s2.done;
			last_s3 <= job_s2.last;
		end
		if (en_s4 && valid_s3) begin
			pen_s4  <= PEN_W'(rate_s3) * PEN_W'(late_s3);
			done_s4 <= done_s3;
			last_s4 <= last_s3;
		end
		if (en_out && valid_s4) begin
			completion_q <= done_s4;
			penalty_q    <= pen_s4;
			cost_q       <= total_next;
			end_q        <= last_s4;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.completion_time = completion_q;
	assign results.job_penalty     = penalty_q;
	assign results.running_cost    = cost_q;
	assign results.schedule_end    = end_q;

endmodule

[rtl/core/setup_tardiness_cost_evaluator.sv]
// Setup tardiness cost evaluator: scores one machine schedule with
// sequence-dependent setup times and weighted tardiness.
//
// items (sink): kind 0 writes setup_time into the setup table at
//   (setup_row, setup_col); kind 1 is the next job of the schedule.
// results (source): one transfer per job, none per load: completion time,
//   the job's penalty, the running cost, and schedule_end = last_job.
// Throughput: one item per cycle while results is not stalled, loads and
//   jobs mixed freely. The table read is issued at the input transfer; the
//   running clock closes its loop through a single register at the stage after the read.
// A job's result is registered through the s1, s2, s3 and s4 registers and then the result register.
// Loads take effect at once: a job right after a load sees the new entry.
// Reset clears the running clock, previous job and cost, and sets the first-job flag.
//   The setup table has no reset and is never cleared; reading an entry that
//   was never written gives an unspecified setup time.
// A job with last_job set closes the schedule; the table is kept.
// When results stalls, finished jobs park in the output register and the
//   pipeline stages close up behind it; items.ready drops only once every
//   stage holds a job.
module setup_tardiness_cost_evaluator #(
	parameter int MAX_JOBS = stc_pkg::MAX_JOBS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	stc_in_if.sink    items,
	stc_out_if.source results
);
	import stc_pkg::*;

	localparam int               DEPTH   = MAX_JOBS * MAX_JOBS;
	localparam int               AW      = $clog2(DEPTH);
	localparam logic [LIM_W-1:0] JOB_LIM = LIM_W'(MAX_JOBS);

	// input side
	logic              en_s1;
	logic              in_fire;
	logic              job_fire;
	logic              load_fire;
	logic              wr_ok;
	logic [JOB_W-1:0]  rd_row;
	logic              rd_oob;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [SETUP_W-1:0] setup_rd;

	// schedule position, tracked at job transfer so the next read can issue
	logic              first_q;
	logic [JOB_W-1:0]  prev_q;

	// stage 1: job waiting on the table read
	logic              valid_s1;
	logic              oob_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [TIME_W-1:0] due_s1;
	logic [RATE_W-1:0] rate_s1;
	logic              last_s1;
	s1_job_t           job_s1;

	logic              s1_take;
	s2_job_t           job_s2;
	logic              s2_take;

	assign en_s1       = !valid_s1 || s1_take;
	assign items.ready = en_s1;
	assign in_fire     = items.valid && en_s1;
	assign job_fire    = in_fire && (items.kind == KIND_JOB);
	assign load_fire   = in_fire && (items.kind == KIND_LOAD);

	// writes outside the table are dropped
	assign wr_ok   = (LIM_W'(items.setup_row) < JOB_LIM) &&
	                 (LIM_W'(items.setup_col) < JOB_LIM);
	assign wr_addr = AW'(32'(items.setup_row) * 32'(MAX_JOBS) + 32'(items.setup_col));

	// first job of a schedule takes its setup from row 0
	assign rd_row  = first_q ? '0 : prev_q;
	assign rd_oob  = !((LIM_W'(rd_row) < JOB_LIM) &&
	                   (LIM_W'(items.job_index) < JOB_LIM));
	assign rd_addr = AW'(32'(rd_row) * 32'(MAX_JOBS) + 32'(items.job_index));

	stc_ram #(
		.WIDTH (SETUP_W),
		.DEPTH (DEPTH)
	) u_setup_ram (
		.clk     (clk),
		.wr_en   (load_fire && wr_ok),
		.wr_addr (wr_addr),
		.wr_data (items.setup_time),
		.rd_en   (job_fire),
		.rd_addr (rd_addr),
		.rd_data (setup_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 1'b1;
			prev_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= job_fire;
			end
			if (job_fire) begin
				first_q <= items.last_job;
				prev_q  <= items.last_job ? '0 : items.job_index;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_fire) begin
			oob_s1  <= rd_oob;
			prod_s1 <= items.production_time;
			due_s1  <= items.due_time;
			rate_s1 <= items.penalty_rate;
			last_s1 <= items.last_job;
		end
	end

	assign job_s1 = '{valid: valid_s1, oob: oob_s1, prod: prod_s1, due: due_s1,
	                  rate: rate_s1, last: last_s1};

	// setup + production on the running clock
	stc_clock u_clock (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_s1   (job_s1),
		.setup_rd (setup_rd),
		.s1_take  (s1_take),
		.job_s2   (job_s2),
		.s2_take  (s2_take)
	);

	// lateness, penalty, running cost, result register
	stc_cost u_cost (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_s2  (job_s2),
		.s2_take (s2_take),
		.results (results)
	);

endmodule

[rtl/core/stc_checker.sv]
// Port-level checker for the tardiness cost evaluator, bound to the top level.
// Depends on stc_pkg and setup_tardiness_cost_evaluator_assert.svh.
`include "setup_tardiness_cost_evaluator_assert.svh"

module stc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        items_ready,
	input logic                        results_valid,
	input logic                        results_ready,
	input logic [stc_pkg::TIME_W-1:0]  completion_time,
	input logic [stc_pkg::PEN_W-1:0]   job_penalty,
	input logic [stc_pkg::COST_W-1:0]  running_cost,
	input logic                        schedule_end
);
	import stc_pkg::*;

	logic              out_fire;
	logic              first_q;
	logic [COST_W-1:0] prev_cost_q;
	logic [TIME_W-1:0] prev_done_q;

	assign out_fire = results_valid && results_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b1;
			prev_cost_q <= '0;
			prev_done_q <= '0;
		end else if (out_fire) begin
			first_q     <= schedule_end;
			prev_cost_q <= running_cost;
			prev_done_q <= completion_time;
		end
	end

	`STC_ASSERT_NEXT(a_result_held, results_valid && !results_ready, results_valid && $stable(running_cost) && $stable(completion_time), "stalled result changed")
	`STC_ASSERT_NOW(a_first_cost, out_fire && first_q, running_cost == COST_W'(job_penalty), "first job cost differs from its penalty")
	`STC_ASSERT_NOW(a_cost_grows, out_fire && !first_q, running_cost >= prev_cost_q, "running cost decreased within a schedule")
	`STC_ASSERT_NOW(a_clock_grows, out_fire && !first_q, completion_time >= prev_done_q, "completion time went back within a schedule")
	`STC_ASSERT_NOW(a_no_idle_stall, !items_ready, results_valid, "input stalled with no result waiting")

endmodule

bind setup_tardiness_cost_evaluator stc_checker u_stc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.items_ready     (items.ready),
	.results_valid   (results.valid),
	.results_ready   (results.ready),
	.completion_time (results.completion_time),
	.job_penalty     (results.job_penalty),
	.running_cost    (results.running_cost),
	.schedule_end    (results.schedule_end)
);

[test/tb_top.sv]
// Self-checking bench for the setup tardiness cost evaluator: setup loads and job sequences
// in, one scored result per job out. Needs stc_pkg, stc_in_if, stc_out_if and the
// setup_tardiness_cost_evaluator RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import stc_pkg::*;

	localparam int TABLE_DIM    = MAX_JOBS_DEFAULT;
	localparam int ITEM_TARGET  = 1700;
	localparam int TAIL_ITEMS   = 150;     // no idling once this few items remain
	localparam int DRAIN_CYCLES = 12;      // drain wait for stray results
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [TIME_W-1:0] TIME_SAT = {TIME_W{1'b1}};
	localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

	// one input item, load or job; unused fields still carry random noise
	typedef struct {
		logic               kind;
		logic [JOB_W-1:0]   setup_row;
		logic [JOB_W-1:0]   setup_col;
		logic [SETUP_W-1:0] setup_time;
		logic [JOB_W-1:0]   job_index;
		logic [PROD_W-1:0]  production_time;
		logic [TIME_W-1:0]  due_time;
		logic [RATE_W-1:0]  penalty_rate;
		logic               last_job;
	} sched_item_t;

	// expected score of one job
	typedef struct {
		logic [TIME_W-1:0] completion;
		logic [PEN_W-1:0]  penalty;
		logic [COST_W-1:0] cost;
		logic              ends;
	} job_score_t;

	logic clk;
	logic arst_n;

	stc_in_if  items_if ();
	stc_out_if res_if ();

	setup_tardiness_cost_evaluator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (res_if)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	sched_item_t sched_items[$];     // items not yet offered to the block
	job_score_t  pending_scores[$];  // scores of accepted jobs, oldest first
	sched_item_t cur_item;           // item currently on the input channel
	int          n_errors;
	int          n_items;
	int          cycles;
	int          idle_pct;
	int          stall_pct;
	int          in_gap;
	int          out_gap;

	// shadow of the block's state, advanced at each accepted transfer
	logic [SETUP_W-1:0] setup_mem [TABLE_DIM][TABLE_DIM];
	logic [TIME_W-1:0]  sched_clock;
	logic [JOB_W-1:0]   prev_job;
	logic               first_job;
	logic [COST_W-1:0]  sched_cost;

	// stimulus-side bookkeeping: which table entries exist, where the sequence stands
	bit                 gen_written [TABLE_DIM][TABLE_DIM];
	logic [JOB_W-1:0]   gen_prev;
	bit                 gen_first;

	// ------------------------------------------------------------------
	// Predictor: scores one accepted item against the shadow state.
	// Loads only touch the table; jobs add setup then production time to
	// the clock (both saturating), charge rate * lateness, and fold the
	// penalty into the saturating schedule cost.
	// ------------------------------------------------------------------
	task automatic score_item(input sched_item_t it);
		logic [JOB_W-1:0]  row;
		logic [TIME_W:0]   sum;
		logic [TIME_W-1:0] start_t;
		logic [TIME_W-1:0] done_t;
		logic [PEN_W-1:0]  pen;
		logic [COST_W:0]   acc;
		job_score_t        sc;
		if (it.kind == KIND_LOAD) begin
			setup_mem[it.setup_row][it.setup_col] = it.setup_time;
			return;
		end
		// first job of a schedule always takes its setup from row 0
		row = first_job ? '0 : prev_job;
		sum = sched_clock + setup_mem[row][it.job_index];
		start_t = sum > TIME_SAT ? TIME_SAT : sum[TIME_W-1:0];
		sum = start_t + it.production_time;
		done_t = sum > TIME_SAT ? TIME_SAT : sum[TIME_W-1:0];
		// finishing exactly on the due time costs nothing
		pen = '0;
		if (done_t > it.due_time)
			pen = it.penalty_rate * (done_t - it.due_time);
		acc = sched_cost + pen;
		sc.completion = done_t;
		sc.penalty    = pen;
		sc.cost       = acc > COST_SAT ? COST_SAT : acc[COST_W-1:0];
		sc.ends       = it.last_job;
		pending_scores.push_back(sc);
		if (it.last_job) begin
			// schedule closes: everything but the table returns to reset
			sched_clock = '0;
			prev_job    = '0;
			first_job   = 1'b1;
			sched_cost  = '0;
		end else begin
			sched_clock = done_t;
			prev_job    = it.job_index;
			first_job   = 1'b0;
			sched_cost  = sc.cost;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	task automatic push_load(input logic [JOB_W-1:0] row, input logic [JOB_W-1:0] col,
			input logic [SETUP_W-1:0] stime);
		sched_item_t it;
		it.kind            = KIND_LOAD;
		it.setup_row       = row;
		it.setup_col       = col;
		it.setup_time      = stime;
		it.job_index       = JOB_W'($urandom);
		it.production_time = PROD_W'($urandom);
		it.due_time        = TIME_W'($urandom);
		it.penalty_rate    = RATE_W'($urandom);
		it.last_job        = 1'($urandom);
		sched_items.push_back(it);
		gen_written[row][col] = 1'b1;
		n_items++;
	endtask

	// Queues a job; first makes sure the table entry it will read exists.
	// Heavy jobs always rewrite that entry with a near-maximum setup time.
	task automatic push_job(input logic [JOB_W-1:0] job, input logic [PROD_W-1:0] prod,
			input logic [TIME_W-1:0] due, input logic [RATE_W-1:0] rate,
			input logic last, input bit heavy);
		sched_item_t      it;
		logic [JOB_W-1:0] row;
		row = gen_first ? '0 : gen_prev;
		if (heavy)
			push_load(row, job, SETUP_W'($urandom_range(65535, 60000)));
		else if (!gen_written[row][job])
			push_load(row, job, SETUP_W'($urandom));
		it.kind            = KIND_JOB;
		it.setup_row       = JOB_W'($urandom);
		it.setup_col       = JOB_W'($urandom);
		it.setup_time      = SETUP_W'($urandom);
		it.job_index       = job;
		it.production_time = prod;
		it.due_time        = due;
		it.penalty_rate    = rate;
		it.last_job        = last;
		sched_items.push_back(it);
		gen_prev  = job;
		gen_first = last;
		n_items++;
	endtask

	function automatic logic [PROD_W-1:0] pick_prod();
		case ($urandom_range(3))
			0: return PROD_W'($urandom);
			1: return PROD_W'($urandom_range(500));
			2: return PROD_W'($urandom_range(20000));
			default: return $urandom_range(1) ? '1 : '0;
		endcase
	endfunction

	// due times spread from "always late" to "never late"
	function automatic logic [TIME_W-1:0] pick_due();
		case ($urandom_range(3))
			0: return TIME_W'($urandom);
			1: return TIME_W'($urandom_range(200000));
			2: return TIME_W'($urandom_range(2000));
			default: return $urandom_range(1) ? '1 : '0;
		endcase
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return RATE_W'($urandom);
		endcase
	endfunction

	task automatic build_stimulus();
		int sched_no;
		int len;
		bit heavy;
		// directed: all-zero job closing at once
		push_load('0, '0, '0);
		push_job('0, '0, '0, '0, 1'b1, 1'b0);
		// widest setup and production on the top index, late at full rate
		push_load('0, 6'd63, '1);
		push_load(6'd63, 6'd63, '1);
		push_job(6'd63, '1, '0, '1, 1'b0, 1'b0);
		// a load in the middle of a schedule leaves the running state alone
		push_load(6'd63, '0, 16'd12345);
		push_job('0, '1, '1, '1, 1'b0, 1'b0);
		push_job(6'd63, 16'd1, '1, '1, 1'b1, 1'b0);
		// finishing exactly at the due time is on time; one unit later is late
		push_load('0, 6'd5, 16'd10);
		push_job(6'd5, 16'd20, 24'd30, 10'd7, 1'b0, 1'b0);
		push_load(6'd5, 6'd5, 16'd1);
		push_job(6'd5, '0, 24'd30, '1, 1'b1, 1'b0);
		// after a schedule end the first job reads row 0, not the old row
		push_load(6'd5, 6'd42, 16'd500);
		push_load('0, 6'd42, 16'd3);
		push_job(6'd42, '0, '0, 10'd1, 1'b1, 1'b0);

		// random schedules; two long heavy ones drive both the clock and
		// the cost into saturation
		sched_no = 0;
		while (n_items < ITEM_TARGET) begin
			heavy = (sched_no == 6) || (sched_no == 70);
			len   = heavy ? $urandom_range(190, 170) : $urandom_range(12, 1);
			for (int j = 0; j < len; j++) begin
				if (heavy) begin
					push_job(JOB_W'($urandom), PROD_W'($urandom_range(65535, 60000)),
						TIME_W'($urandom_range(5000)), RATE_W'($urandom_range(1023, 900)),
						j == len - 1, 1'b1);
				end else begin
					if ($urandom_range(3) == 0)
						push_load(JOB_W'($urandom), JOB_W'($urandom), SETUP_W'($urandom));
					push_job(JOB_W'($urandom), pick_prod(), pick_due(), pick_rate(),
						j == len - 1, 1'b0);
				end
			end
			sched_no++;
		end
	endtask

	// ------------------------------------------------------------------
	// Input driver: offers queued items; on each accepted transfer the
	// predictor advances. Valid drops only during random idle bursts and once the queue is empty.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_if.valid <= 1'b0;
			in_gap         <= 0;
		end else begin
			if (items_if.valid && items_if.ready)
				score_item(cur_item);
			if (!items_if.valid || items_if.ready) begin
				if (in_gap != 0) begin
					in_gap         <= in_gap - 1;
					items_if.valid <= 1'b0;
				end else if (sched_items.size() >= TAIL_ITEMS &&
						$urandom_range(99) < idle_pct) begin
					// start an idle burst, this one included; in_gap holds the rest of it
					in_gap         <= $urandom_range(5, 0);
					items_if.valid <= 1'b0;
				end else if (sched_items.size() != 0) begin
					cur_item = sched_items.pop_front();
					items_if.kind            <= cur_item.kind;
					items_if.setup_row       <= cur_item.setup_row;
					items_if.setup_col       <= cur_item.setup_col;
					items_if.setup_time      <= cur_item.setup_time;
					items_if.job_index       <= cur_item.job_index;
					items_if.production_time <= cur_item.production_time;
					items_if.due_time        <= cur_item.due_time;
					items_if.penalty_rate    <= cur_item.penalty_rate;
					items_if.last_job        <= cur_item.last_job;
					items_if.valid           <= 1'b1;
				end else begin
					items_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: each accepted result transfer is checked against
	// the oldest expected score. Ready stalls in random bursts.
	// ------------------------------------------------------------------
	task automatic check_result();
		job_score_t sc;
		if (pending_scores.size() == 0) begin
			$error("result with no job outstanding: completion_time %0d",
				res_if.completion_time);
			n_errors++;
			return;
		end
		sc = pending_scores.pop_front();
		if (res_if.completion_time !== sc.completion) begin
			$error("completion_time: expected %0d, actual %0d",
				sc.completion, res_if.completion_time);
			n_errors++;
		end
		if (res_if.job_penalty !== sc.penalty) begin
			$error("job_penalty: expected %0d, actual %0d", sc.penalty, res_if.job_penalty);
			n_errors++;
		end
		if (res_if.running_cost !== sc.cost) begin
			$error("running_cost: expected %0d, actual %0d", sc.cost, res_if.running_cost);
			n_errors++;
		end
		if (res_if.schedule_end !== sc.ends) begin
			$error("schedule_end: expected %0d, actual %0d", sc.ends, res_if.schedule_end);
			n_errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			out_gap      <= 0;
		end else begin
			if (res_if.valid && res_if.ready)
				check_result();
			if (out_gap != 0) begin
				out_gap      <= out_gap - 1;
				res_if.ready <= 1'b0;
			end else if (sched_items.size() >= TAIL_ITEMS &&
					$urandom_range(99) < stall_pct) begin
				out_gap      <= $urandom_range(5, 0);
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Cycle count: re-rolls the idle and stall rates so calm stretches
	// alternate with busy ones, and bounds the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles % 256 == 0) begin
			case ($urandom_range(2))
				0: idle_pct = 0;
				1: idle_pct = 12;
				default: idle_pct = 35;
			endcase
			case ($urandom_range(2))
				0: stall_pct = 0;
				1: stall_pct = 12;
				default: stall_pct = 35;
			endcase
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, build the item list, let it drain, then report.
	// ------------------------------------------------------------------
	initial begin
		arst_n                   = 1'b0;
		items_if.valid           = 1'b0;
		items_if.kind            = KIND_LOAD;
		items_if.setup_row       = '0;
		items_if.setup_col       = '0;
		items_if.setup_time      = '0;
		items_if.job_index       = '0;
		items_if.production_time = '0;
		items_if.due_time        = '0;
		items_if.penalty_rate    = '0;
		items_if.last_job        = 1'b0;
		res_if.ready             = 1'b0;
		n_errors    = 0;
		n_items     = 0;
		cycles      = 0;
		idle_pct    = 12;
		stall_pct   = 12;
		sched_clock = '0;
		prev_job    = '0;
		first_job   = 1'b1;
		sched_cost  = '0;
		gen_prev    = '0;
		gen_first   = 1'b1;
		build_stimulus();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// every item offered and taken
		while (sched_items.size() != 0 || items_if.valid)
			@(posedge clk);
		while (pending_scores.size() != 0)
			@(posedge clk);
		// keep waiting to catch stray results
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_scores.size() != 0) begin
			$error("%0d job results never arrived", pending_scores.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
